@@ sv/rcd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants for the rgb 3x3 convolution core.
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int unsigned PixBits  = 8;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned ProdW    = 25;
  localparam int unsigned RowSumW  = 27;
  localparam int unsigned SumW     = 29;
  localparam int unsigned MagW     = 28;
  localparam int unsigned DivW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned MaxHeight = 1024;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WIDTH    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COEF_TOP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COEF_MID = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COEF_BOT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DIVISOR  = 3'd5;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;
  } rcd_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [9:0] center_row;
    logic [9:0] center_col;
    logic       frame_last;
  } rcd_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WIN,
    S_START,
    S_LANE
  } top_state_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_ADD,
    L_SUM,
    L_DIV,
    L_DONE
  } lane_state_e;

endpackage

@@ sv/rcd_lane.sv @@
// ----------------------------------------------------------------------------
// rcd_lane
// One color channel: nine products, adder tree, bit-serial divide, clamp.
// ----------------------------------------------------------------------------
module rcd_lane
  import rcd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [8:0][PixBits-1:0] pix_i,
  input  logic [8:0][CoefW-1:0]   coef_i,
  input  logic [DivW-1:0]         divisor_i,
  output logic                    done_o,
  output logic [PixBits-1:0]      value_o
);

  lane_state_e state_q;
  logic [4:0]  cnt_q;

  logic signed [ProdW-1:0]   prod_q [9];
  logic signed [RowSumW-1:0] row_q [3];
  logic                      neg_q;
  logic [MagW-1:0]           quo_q;
  logic [DivW-1:0]           rem_q;

  logic signed [SumW-1:0] sum;
  logic [DivW:0]          trial;
  logic [DivW:0]          dv;
  logic                   fits;

  // total of the three row sums
  assign sum = SumW'(row_q[0]) + SumW'(row_q[1]) + SumW'(row_q[2]);

  // one restoring divide step
  assign dv    = (divisor_i == '0) ? (DivW+1)'(1) : {1'b0, divisor_i};
  assign trial = {rem_q, quo_q[MagW-1]};
  assign fits  = (trial >= dv);

  // sequencer, fixed length so all lanes finish together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
    end else if (start_i) begin
      state_q <= L_ADD;
    end else begin
      case (state_q)
        L_ADD: state_q <= L_SUM;
        L_SUM: begin
          cnt_q   <= 5'(MagW - 1);
          state_q <= L_DIV;
        end
        L_DIV: begin
          if (cnt_q == '0) state_q <= L_DONE;
          cnt_q <= cnt_q - 5'd1;
        end
        default: state_q <= state_q;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int k = 0; k < 9; k++) begin
        prod_q[k] <= ProdW'($signed({1'b0, pix_i[k]}) * $signed(coef_i[k]));
      end
    end else begin
      case (state_q)
        L_ADD: begin
          for (int r = 0; r < 3; r++) begin
            row_q[r] <= RowSumW'(prod_q[3*r]) + RowSumW'(prod_q[3*r+1])
                      + RowSumW'(prod_q[3*r+2]);
          end
        end
        L_SUM: begin
          neg_q <= sum[SumW-1];
          quo_q <= sum[MagW-1:0];
          rem_q <= '0;
        end
        L_DIV: begin
          rem_q <= fits ? DivW'(trial - dv) : trial[DivW-1:0];
          quo_q <= {quo_q[MagW-2:0], fits};
        end
        default: ;
      endcase
    end
  end

  // negative sums clamp to zero, large ones to full scale
  assign done_o  = (state_q == L_DONE);
  assign value_o = neg_q ? '0 : ((quo_q > MagW'(255)) ? 8'hFF : quo_q[PixBits-1:0]);

endmodule

@@ sv/rgb_conv3x3_divide_clamp_core.sv @@
// ----------------------------------------------------------------------------
// rgb_conv3x3_divide_clamp_core
// 3x3 convolution on an rgb pixel stream with divide and clamp.
// ----------------------------------------------------------------------------
// An interior pixel passes window update, multiply, two add stages, 28-step
// divide and output load after acceptance, in that order.
// No new pixel is accepted until the last one is done; for interior centers
// the bit-serial divider in each channel lane holds the input, as can a full output.
// Reset: asynchronous active low; registers to defaults, position to zero.
// Line stores are not cleared and hold data only once a row has passed.
module rgb_conv3x3_divide_clamp_core
  import rcd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned COEF_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rcd_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rcd_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW = 13;

  // configuration registers
  logic [10:0]         width_q, height_q;
  logic [CfgDataW-1:0] coef_top_q, coef_mid_q, coef_bot_q;
  logic [DivW-1:0]     div_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 11'd1024;
      height_q   <= 11'd1024;
      coef_top_q <= '0;
      coef_mid_q <= 48'h0000_0001_0000;
      coef_bot_q <= '0;
      div_q      <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:    width_q    <= cfg_data_i[10:0];
        CFG_HEIGHT:   height_q   <= cfg_data_i[10:0];
        CFG_COEF_TOP: coef_top_q <= cfg_data_i;
        CFG_COEF_MID: coef_mid_q <= cfg_data_i;
        CFG_COEF_BOT: coef_bot_q <= cfg_data_i;
        CFG_DIVISOR:  div_q      <= cfg_data_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // saturated frame size
  logic [SW-1:0] w13, h13;
  logic [PW-1:0] w;
  logic [10:0]   h;

  assign w13 = (SW'(width_q) < SW'(3)) ? SW'(3)
             : ((SW'(width_q) > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : SW'(width_q));
  assign h13 = (SW'(height_q) < SW'(3)) ? SW'(3)
             : ((SW'(height_q) > SW'(MaxHeight)) ? SW'(MaxHeight) : SW'(height_q));
  assign w = w13[PW-1:0];
  assign h = h13[10:0];

  // control state
  top_state_e    state_q, state_d;
  logic [PW-1:0] pos_col_q;
  logic [9:0]    pos_row_q;
  logic          produce_q;
  logic          out_vld_q;
  rcd_out_t      out_q;
  logic [2:0]    lane_done;
  logic [2:0][PixBits-1:0] lane_val;

  logic in_acc, out_free, lane_start, load_out;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // position of the incoming pixel and of the next one
  logic [PW-1:0] pc0, c, nc;
  logic [10:0]   pr0, pr1, r, nr;
  logic          prod_now, last_now;

  always_comb begin
    pc0 = in_data_i.frame_start ? '0 : pos_col_q;
    pr0 = in_data_i.frame_start ? '0 : {1'b0, pos_row_q};
    c   = pc0;
    pr1 = pr0;
    if (pc0 >= w) begin
      c   = '0;
      pr1 = pr0 + 11'd1;
    end
    r = (pr1 >= h) ? '0 : pr1;
    nc = c + PW'(1);
    nr = r;
    if (nc >= w) begin
      nc = '0;
      nr = r + 11'd1;
      if (nr >= h) nr = '0;
    end
    prod_now = (r >= 11'd2) && (c >= PW'(2));
    last_now = (r == h - 11'd1) && (c == w - PW'(1));
  end

  // line stores with registered read
  logic [23:0] line_above   [MAX_WIDTH];
  logic [23:0] line_two_above [MAX_WIDTH];
  logic [23:0] above_rd_q, two_rd_q, pix_q;
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_rd_q <= line_above[c[AW-1:0]];
      two_rd_q   <= line_two_above[c[AW-1:0]];
    end
    if (state_q == S_WIN) begin
      line_two_above[addr_q] <= above_rd_q;
      line_above[addr_q]     <= pix_q;
    end
  end

  // accepted pixel and its result tags
  logic [9:0] tag_row_q, tag_col_q;
  logic       tag_last_q;
  logic [PW-1:0] cm1;
  logic [10:0]   rm1;

  assign cm1 = c - PW'(1);
  assign rm1 = r - 11'd1;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q      <= {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};
      addr_q     <= c[AW-1:0];
      tag_row_q  <= rm1[9:0];
      tag_col_q  <= 10'(cm1);
      tag_last_q <= last_now;
    end
  end

  // 3x3 window, rightmost column taken from the stores and the new pixel
  logic [8:0][23:0] win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (state_q == S_WIN) begin
      for (int k = 0; k < 3; k++) begin
        win_q[3*k]   <= win_q[3*k+1];
        win_q[3*k+1] <= win_q[3*k+2];
      end
      win_q[2] <= two_rd_q;
      win_q[5] <= above_rd_q;
      win_q[8] <= pix_q;
    end
  end

  // coefficients: low COEF_BITS of each slot, sign extended
  logic [8:0][CoefW-1:0] coef;

  for (genvar k = 0; k < 9; k++) begin : g_coef
    logic [CfgDataW-1:0] rowreg;
    logic [CoefW-1:0]    slot;
    assign rowreg = (k / 3 == 0) ? coef_top_q : ((k / 3 == 1) ? coef_mid_q : coef_bot_q);
    assign slot   = rowreg[CoefW*(k%3) +: CoefW];
    assign coef[k] = CoefW'($signed(slot << (CoefW - COEF_BITS)) >>> (CoefW - COEF_BITS));
  end

  // channel lanes
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    logic [8:0][PixBits-1:0] lpix;
    for (genvar k = 0; k < 9; k++) begin : g_pix
      assign lpix[k] = win_q[k][PixBits*ch +: PixBits];
    end
    rcd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (lane_start),
      .pix_i     (lpix),
      .coef_i    (coef),
      .divisor_i (div_q),
      .done_o    (lane_done[ch]),
      .value_o   (lane_val[ch])
    );
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    lane_start = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_WIN;
      S_WIN:   state_d = produce_q ? S_START : S_IDLE;
      S_START: begin
        lane_start = 1'b1;
        state_d    = S_LANE;
      end
      S_LANE: begin
        if (lane_done[0] && out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_col_q <= '0;
      pos_row_q <= '0;
      produce_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        pos_col_q <= nc;
        pos_row_q <= nr[9:0];
        produce_q <= prod_now;
      end
    end
  end

  // output register, merges the three lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.red_out    <= lane_val[0];
      out_q.green_out  <= lane_val[1];
      out_q.blue_out   <= lane_val[2];
      out_q.center_row <= tag_row_q;
      out_q.center_col <= tag_col_q;
      out_q.frame_last <= tag_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // lanes run in lockstep
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
    else $error("lanes out of step");

  // an accepted pixel goes to the window update next
  a_acc_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_WIN))
    else $error("window update missed");

  // a border pixel returns to idle without loading a word
  a_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WIN && !produce_q) |=> (state_q == S_IDLE && !load_out))
    else $error("border pixel produced a word");

  // a word is loaded only when the lanes have finished
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == S_LANE && lane_done[0]))
    else $error("word loaded early");

endmodule
